// File: src/rfcp_pkg.sv
// ----------------------------------------------------------------------------
// rfcp_pkg
// Shared types and constants of the rarest-first chunk picker: the input and
// result words, opcodes, sequencer states and the table sizing.
// ----------------------------------------------------------------------------
package rfcp_pkg;

    // table sizing
    localparam int MAX_CHUNKS  = 256;
    localparam int CHUNK_BYTES = 1024;
    localparam int PICKS       = 4;

    localparam int IDX_W   = $clog2(MAX_CHUNKS);
    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int SHIFT_W = $clog2(CHUNK_BYTES);
    localparam int PICK_W  = (PICKS > 1) ? $clog2(PICKS) : 1;
    localparam int HOLD_W  = 16;
    localparam int LEN_W   = 32;
    localparam int CIDX_W  = 32;
    localparam int OIDX_W  = 8;

    localparam logic [HOLD_W-1:0] COUNT_MAX = '1;

    // opcodes of an input word
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_MARK   = 2'd2,
        OP_SELECT = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [CIDX_W-1:0]   chunk_sel;
    } t_in_word;

    typedef struct packed {
        logic [OIDX_W-1:0]   picked_chunk;
        logic                found;
        logic                last;
    } t_out_word;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_READ,
        S_ADD_WRITE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

// File: src/rarest_first_chunk_picker.sv
// ----------------------------------------------------------------------------
// rarest_first_chunk_picker
// Holder-count table with possessed marks; a select scans the chunks in use
// and returns up to PICKS not-possessed chunks, fewest holders first.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  input     i_word (opcode, chunk_sel)     taken when start high, busy low
//  result    o_word (picked, found, last)   o_strobe high with each word
//  config    i_cfg_data (file size)         written when i_cfg_we high
//
//  Clear and mark possessed act at accept; add holder steps through accept,
//  read, then a saturating write over the table's read and write ports. A
//  select steps through accept, a scan of the chunk_count entries, a drain
//  step into one running top-PICKS insertion unit, then the result words
//  (at most PICKS); each word leaves through a register in the next cycle.
//  Clear is instant: per-entry valid bits make untouched entries read as
//  zero. Synchronous active-low reset; the receiver cannot stall.
//
module rarest_first_chunk_picker
    import rfcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_word          i_word,
    output logic              o_strobe,
    output t_out_word         o_word,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    // state and control
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_scan_idx;
    logic [PICK_W-1:0]     r_emit_ptr;
    logic                  r_pipe_vld;
    logic [IDX_W-1:0]      r_pipe_idx;

    // table storage
    logic [HOLD_W-1:0]     r_mem [MAX_CHUNKS];
    logic [HOLD_W-1:0]     r_mem_q;
    logic [MAX_CHUNKS-1:0] r_valid;
    logic [MAX_CHUNKS-1:0] r_poss;
    logic                  r_rd_valid;
    logic                  r_rd_poss;

    // running top list, sorted by holders then index
    logic [HOLD_W-1:0]     r_top_cnt [PICKS];
    logic [IDX_W-1:0]      r_top_idx [PICKS];
    logic [PICKS-1:0]      r_top_vld;

    // result word
    logic                  r_strobe;
    t_out_word             r_out;
    logic                  n_strobe;
    t_out_word             n_out;

    logic                  accept;
    logic                  in_range;
    logic [IDX_W-1:0]      raddr;
    logic [HOLD_W-1:0]     rd_cnt;
    logic [LEN_W:0]        len_sum;
    logic [LEN_W-SHIFT_W:0] chunks_raw;
    logic [CNT_W-1:0]      n_count;
    logic                  ins_en;
    logic [PICKS-1:0]      lt;
    logic                  next_vld;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign in_range = (i_word.chunk_sel < {{(CIDX_W-CNT_W){1'b0}}, r_count});
    assign raddr    = (r_state == S_SCAN) ? r_scan_idx : r_idx;
    assign rd_cnt   = r_rd_valid ? r_mem_q : '0;
    assign o_strobe = r_strobe;
    assign o_word   = r_out;

    // chunk count = ceil(file size / CHUNK_BYTES), capped at table depth
    assign len_sum    = {1'b0, i_cfg_data} + (LEN_W+1)'(CHUNK_BYTES - 1);
    assign chunks_raw = len_sum[LEN_W:SHIFT_W];
    always_comb begin
        if (chunks_raw > (LEN_W-SHIFT_W+1)'(MAX_CHUNKS)) begin
            n_count = CNT_W'(MAX_CHUNKS);
        end else begin
            n_count = chunks_raw[CNT_W-1:0];
        end
    end

    // insertion compare: first slot that is empty or holds more holders
    assign ins_en = r_pipe_vld && !r_rd_poss;
    always_comb begin
        for (int k = 0; k < PICKS; k++) begin
            lt[k] = !r_top_vld[k] || (rd_cnt < r_top_cnt[k]);
        end
    end

    // next state and result word
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_out    = '0;
        next_vld = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_word.opcode)
                        OP_ADD: begin
                            if (in_range) begin
                                n_state = S_ADD_READ;
                            end
                        end
                        OP_SELECT: begin
                            n_state = (r_count == '0) ? S_EMIT : S_SCAN;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_READ:  n_state = S_ADD_WRITE;
            S_ADD_WRITE: n_state = S_IDLE;
            S_SCAN: begin
                if ({1'b0, r_scan_idx} == r_count - CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (r_emit_ptr != PICK_W'(PICKS - 1)) begin
                    next_vld = r_top_vld[r_emit_ptr + PICK_W'(1)];
                end
                n_strobe           = 1'b1;
                n_out.picked_chunk = r_top_vld[r_emit_ptr] ?
                                     OIDX_W'(r_top_idx[r_emit_ptr]) : '0;
                n_out.found        = r_top_vld[r_emit_ptr];
                n_out.last         = !next_vld;
                if (!next_vld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_strobe   <= 1'b0;
            r_pipe_vld <= 1'b0;
            r_valid    <= '0;
            r_poss     <= '0;
            r_top_vld  <= '0;
        end else begin
            r_state    <= n_state;
            r_strobe   <= n_strobe;
            r_pipe_vld <= (r_state == S_SCAN);
            if (i_cfg_we) begin
                r_count <= n_count;
            end
            // table updates issued from idle
            if (r_state == S_IDLE && accept) begin
                case (i_word.opcode)
                    OP_CLEAR: begin
                        r_valid <= '0;
                        r_poss  <= '0;
                    end
                    OP_MARK: begin
                        if (in_range) begin
                            r_poss[i_word.chunk_sel[IDX_W-1:0]] <= 1'b1;
                        end
                    end
                    OP_SELECT: r_top_vld <= '0;
                    default: ;
                endcase
            end
            if (r_state == S_ADD_WRITE) begin
                r_valid[r_idx] <= 1'b1;
            end
            // shift the running list down at the insertion slot
            if (ins_en) begin
                for (int k = 0; k < PICKS; k++) begin
                    if (lt[k]) begin
                        if (k == 0) begin
                            r_top_vld[k] <= 1'b1;
                        end else begin
                            r_top_vld[k] <= lt[k-1] ? r_top_vld[k-1] : 1'b1;
                        end
                    end
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && accept) begin
            r_idx      <= i_word.chunk_sel[IDX_W-1:0];
            r_scan_idx <= '0;
            r_emit_ptr <= '0;
        end
        if (r_state == S_SCAN) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        if (r_state == S_EMIT) begin
            r_emit_ptr <= r_emit_ptr + PICK_W'(1);
        end
        r_pipe_idx <= r_scan_idx;
        if (ins_en) begin
            for (int k = 0; k < PICKS; k++) begin
                if (lt[k]) begin
                    if (k == 0) begin
                        r_top_cnt[k] <= rd_cnt;
                        r_top_idx[k] <= r_pipe_idx;
                    end else if (lt[k-1]) begin
                        r_top_cnt[k] <= r_top_cnt[k-1];
                        r_top_idx[k] <= r_top_idx[k-1];
                    end else begin
                        r_top_cnt[k] <= rd_cnt;
                        r_top_idx[k] <= r_pipe_idx;
                    end
                end
            end
        end
    end

    // holder-count memory: one read, one saturating write
    always_ff @(posedge i_clk) begin
        r_mem_q    <= r_mem[raddr];
        r_rd_valid <= r_valid[raddr];
        r_rd_poss  <= r_poss[raddr];
        if (r_state == S_ADD_WRITE && rd_cnt != COUNT_MAX) begin
            r_mem[r_idx] <= rd_cnt + HOLD_W'(1);
        end
    end

endmodule
